>>> design/mcrt_pkg.sv
package mcrt_pkg;

    localparam int NUM_TIMERS_DEF = 8;
    localparam int MAX_RESULTS    = 8;
    localparam int IDX_W          = 6;   // covers up to 64 channels
    localparam int RANK_W         = 7;   // holds a rank up to 64

    localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

    localparam logic [2:0] K_TICK  = 3'd0;
    localparam logic [2:0] K_CFG   = 3'd1;
    localparam logic [2:0] K_START = 3'd2;
    localparam logic [2:0] K_STOP  = 3'd3;
    localparam logic [2:0] K_QUERY = 3'd4;

    localparam logic [1:0] ST_INIT = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_STOP = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_ROT,
        OP_FIRE,
        OP_CFG,
        OP_START,
        OP_STOP
    } t_op;

    typedef struct packed {
        t_op  op;
        logic hit;
    } t_cell_ctl;

    typedef struct packed {
        logic [31:0]      age;
        logic [IDX_W-1:0] idx;
        logic             elig;
    } t_ring;

    typedef struct packed {
        logic [1:0]        state;
        logic [15:0]       count;
        logic [RANK_W-1:0] rank;
        logic              elig;
        logic [1:0]        fire_state;
        logic [15:0]       fire_count;
    } t_cell_stat;

endpackage

>>> design/mcrt_cell.sv
module mcrt_cell
    import mcrt_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cell_ctl   i_ctl,
    input  logic [31:0] i_tick,
    input  logic [31:0] i_interval,
    input  logic [15:0] i_count,
    input  t_ring       i_ring,
    output t_ring       o_ring,
    output t_cell_stat  o_stat
);

    logic [31:0]       r_deadline;
    logic [31:0]       r_period;
    logic [15:0]       r_count;
    logic [1:0]        r_state;
    logic [31:0]       r_age;
    logic              r_elig;
    logic [RANK_W-1:0] r_rank;
    t_ring             r_ring;

    logic [31:0] w_age;
    logic        w_elig;
    logic [15:0] w_fire_count;
    logic [1:0]  w_fire_state;
    logic        w_beats;

    assign w_age  = i_tick - r_deadline;
    assign w_elig = (r_state == ST_RUN) && (w_age < HALF_RANGE);

    // positive counts step down, negative ones run forever
    assign w_fire_count = (r_count != 16'd0 && !r_count[15]) ? r_count - 16'd1 : r_count;
    assign w_fire_state = (w_fire_count != 16'd0) ? ST_RUN : ST_STOP;

    // older neighbor, or same age from a lower channel, ranks ahead of us
    assign w_beats = i_ring.elig && ((i_ring.age > r_age) ||
                     ((i_ring.age == r_age) && (i_ring.idx < IDX_W'(IDX))));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_STOP;
            r_elig  <= 1'b0;
            r_rank  <= '0;
        end else begin
            case (i_ctl.op)
                OP_LOAD: begin
                    r_elig <= w_elig;
                    r_rank <= '0;
                end
                OP_ROT: begin
                    if (w_beats) begin
                        r_rank <= r_rank + RANK_W'(1);
                    end
                end
                OP_FIRE: begin
                    if (i_ctl.hit) begin
                        r_state <= w_fire_state;
                    end
                end
                OP_CFG: begin
                    if (i_ctl.hit) begin
                        r_state <= ST_INIT;
                    end
                end
                OP_START: begin
                    if (i_ctl.hit) begin
                        r_state <= ST_RUN;
                    end
                end
                OP_STOP: begin
                    if (i_ctl.hit) begin
                        r_state <= ST_STOP;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_LOAD: begin
                r_age  <= w_age;
                r_ring <= '{age: w_age, idx: IDX_W'(IDX), elig: w_elig};
            end
            OP_ROT: begin
                r_ring <= i_ring;
            end
            OP_FIRE: begin
                if (i_ctl.hit) begin
                    r_count <= w_fire_count;
                    if (w_fire_count != 16'd0) begin
                        r_deadline <= i_tick + r_period;
                    end
                end
            end
            OP_CFG: begin
                if (i_ctl.hit) begin
                    r_period <= (i_interval == 32'd0) ? 32'd1 : i_interval;
                    r_count  <= i_count;
                end
            end
            OP_START: begin
                if (i_ctl.hit) begin
                    r_deadline <= i_tick + r_period;
                end
            end
            default: ;
        endcase
    end

    assign o_ring = r_ring;
    assign o_stat = '{state: r_state, count: r_count, rank: r_rank, elig: r_elig,
                      fire_state: w_fire_state, fire_count: w_fire_count};

endmodule

>>> design/multi_channel_repeat_timer_core.sv
// Repeat timer with NUM_TIMERS channels kept in a ring of cells. Commands come
// in as one word each, the kind in tuser; a query answers with one status
// word. A tick advances the 32-bit tick counter and then sorts the expired
// channels: every cell latches its age, the ages circulate once around the
// ring so each cell learns its rank, and the cells then fire in rank order,
// oldest first with ties to the lower channel, one expiry word per cycle
// while the output is not stalled, at most eight per tick. tlast marks the
// final word caused by one input word. Channels never configured must not
// be started.
module multi_channel_repeat_timer_core
    import mcrt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // channel[2:0], interval[34:3], repeat_count[50:35]
    input  logic [2:0]  i_s_tuser,   // kind[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // channel_out[2:0], channel_status[4:3], remaining[20:5]
    output logic [0:0]  o_m_tuser,   // result_kind[0]
    output logic        o_m_tlast
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_ROT  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state            r_state;
    logic [31:0]       r_tick;
    logic [IW-1:0]     r_rot;
    logic [RANK_W-1:0] r_rank;
    logic              r_m_valid;
    logic [23:0]       r_m_data;
    logic              r_m_user;
    logic              r_m_last;

    logic [2:0]  w_kind;
    logic [2:0]  w_ch;
    logic [31:0] w_ival;
    logic [15:0] w_rc;
    logic        w_acc;
    logic        w_out_free;
    logic        w_ch_ok;

    t_ring      w_ring [NUM_TIMERS];
    t_cell_stat w_stat [NUM_TIMERS];
    t_cell_ctl  w_ctl  [NUM_TIMERS];

    logic [NUM_TIMERS-1:0] w_hit_r;
    logic [NUM_TIMERS-1:0] w_hit_n;
    logic        w_cap_ok;
    logic        w_emit;
    logic        w_is_last;
    logic [2:0]  w_fire_ch;
    logic [1:0]  w_fire_st;
    logic [15:0] w_fire_cnt;
    logic [1:0]  w_q_st;
    logic [15:0] w_q_cnt;

    assign w_ch   = i_s_tdata[2:0];
    assign w_ival = i_s_tdata[34:3];
    assign w_rc   = i_s_tdata[50:35];
    assign w_kind = i_s_tuser;

    assign w_out_free = !r_m_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_out_free;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_ch_ok    = int'(w_ch) < NUM_TIMERS;

    // cap expiries per tick; ranks are dense so a miss ends the list
    assign w_cap_ok  = int'(r_rank) < MAX_RESULTS;
    assign w_emit    = (r_state == S_EMIT) && w_out_free && (|w_hit_r) && w_cap_ok;
    assign w_is_last = !(|w_hit_n) || (int'(r_rank) + 1 >= MAX_RESULTS);

    always_comb begin
        w_fire_ch  = '0;
        w_fire_st  = '0;
        w_fire_cnt = '0;
        w_q_st     = ST_STOP;
        w_q_cnt    = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            w_hit_r[i] = w_stat[i].elig && (w_stat[i].rank == r_rank);
            w_hit_n[i] = w_stat[i].elig && (w_stat[i].rank == r_rank + RANK_W'(1));
            if (w_hit_r[i]) begin
                w_fire_ch  = 3'(i);
                w_fire_st  = w_stat[i].fire_state;
                w_fire_cnt = w_stat[i].fire_count;
            end
            if (int'(w_ch) == i) begin
                w_q_st  = w_stat[i].state;
                w_q_cnt = w_stat[i].count;
            end
        end
    end

    // drive each cell's command
    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            w_ctl[i].op  = OP_NONE;
            w_ctl[i].hit = 1'b0;
            case (r_state)
                S_IDLE: begin
                    w_ctl[i].hit = w_ch_ok && (int'(w_ch) == i);
                    if (w_acc) begin
                        case (w_kind)
                            K_CFG:   w_ctl[i].op = OP_CFG;
                            K_START: w_ctl[i].op = OP_START;
                            K_STOP:  w_ctl[i].op = OP_STOP;
                            default: w_ctl[i].op = OP_NONE;
                        endcase
                    end
                end
                S_LOAD: w_ctl[i].op = OP_LOAD;
                S_ROT:  w_ctl[i].op = OP_ROT;
                S_EMIT: begin
                    w_ctl[i].op  = w_emit ? OP_FIRE : OP_NONE;
                    w_ctl[i].hit = w_hit_r[i];
                end
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        mcrt_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[g]),
            .i_tick     (r_tick),
            .i_interval (w_ival),
            .i_count    (w_rc),
            .i_ring     (w_ring[(g + NUM_TIMERS - 1) % NUM_TIMERS]),
            .o_ring     (w_ring[g]),
            .o_stat     (w_stat[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tick    <= '0;
            r_rot     <= '0;
            r_rank    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc && w_kind == K_TICK) begin
                        r_tick  <= r_tick + 32'd1;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_rot   <= '0;
                    r_rank  <= '0;
                    r_state <= (NUM_TIMERS > 1) ? S_ROT : S_EMIT;
                end
                S_ROT: begin
                    r_rot <= r_rot + IW'(1);
                    if (int'(r_rot) == NUM_TIMERS - 2) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_emit) begin
                        r_rank    <= r_rank + RANK_W'(1);
                        if (w_is_last) begin
                            r_state <= S_IDLE;
                        end
                    end else if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // load a new word when one is produced, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_emit || (w_acc && w_kind == K_QUERY)) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // hold the payload until the word is taken
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_m_data <= {3'b000, w_fire_cnt, w_fire_st, w_fire_ch};
            r_m_user <= 1'b0;
            r_m_last <= w_is_last;
        end else if (w_acc && w_kind == K_QUERY) begin
            r_m_data <= w_ch_ok ? {3'b000, w_q_cnt, w_q_st, w_ch}
                                : {3'b000, 16'd0, ST_STOP, w_ch};
            r_m_user <= 1'b1;
            r_m_last <= 1'b1;
        end
    end

    assign o_m_tvalid   = r_m_valid;
    assign o_m_tdata    = r_m_data;
    assign o_m_tuser[0] = r_m_user;
    assign o_m_tlast    = r_m_last;

    // input is taken only between ticks
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (r_state == S_IDLE))
        else $error("input ready outside idle");

    // at most one cell fires per cycle
    a_one_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> $onehot0(w_hit_r))
        else $error("two cells share a rank");

    // never more expiries per tick than the cap
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (int'(r_rank) <= MAX_RESULTS))
        else $error("expiry cap exceeded");

endmodule
